// ----- hdl/glpg_pkg.sv -----
// shared constant and controller/datapath interface types for the grid line point generator
package glpg_pkg;

  localparam int COORD_BITS_DEF = 6;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture request, form deltas and step signs
    logic setup;  // pick major axis, seed error term and count
    logic step;   // advance to the next cell of the line
  } glpg_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last;   // current cell is the final one
  } glpg_status_t;

endpackage

// ----- hdl/glpg_dp.sv -----
// datapath of the grid line point generator: coordinates, error term and cell count
module glpg_dp #(
  parameter int COORD_BITS = glpg_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  glpg_pkg::glpg_cmd_t     cmd,
  input  logic [4*COORD_BITS-1:0] req,      // start_col, start_row, end_col, end_row
  output glpg_pkg::glpg_status_t  status,
  output logic [COORD_BITS-1:0]   point_col,
  output logic [COORD_BITS-1:0]   point_row
);
  import glpg_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 3;

  // request fields
  logic [CB-1:0] in_col;
  logic [CB-1:0] in_row;
  logic [CB-1:0] in_tcol;
  logic [CB-1:0] in_trow;
  logic [CB:0]   dc;
  logic [CB:0]   dr;
  logic [CB:0]   dc_mag;
  logic [CB:0]   dr_mag;

  // registers
  logic [CB-1:0]        col;
  logic [CB-1:0]        row;
  logic                 col_neg;
  logic                 row_neg;
  logic [CB-1:0]        adc;
  logic [CB-1:0]        adr;
  logic                 col_major;
  logic                 tie_moves;
  logic [CB-1:0]        major;
  logic [CB-1:0]        minor;
  logic signed [DW-1:0] d;
  logic [CB-1:0]        cnt;

  // setup and step logic
  logic                 col_major_next;
  logic [CB-1:0]        major_next;
  logic [CB-1:0]        minor_next;
  logic signed [DW-1:0] d_init;
  logic signed [DW-1:0] two_major;
  logic signed [DW-1:0] two_minor;
  logic                 move;
  logic [CB-1:0]        col_adv;
  logic [CB-1:0]        row_adv;

  assign in_col  = req[CB-1:0];
  assign in_row  = req[2*CB-1:CB];
  assign in_tcol = req[3*CB-1:2*CB];
  assign in_trow = req[4*CB-1:3*CB];

  assign dc     = {1'b0, in_tcol} - {1'b0, in_col};
  assign dr     = {1'b0, in_trow} - {1'b0, in_row};
  assign dc_mag = dc[CB] ? (~dc + 1'b1) : dc;
  assign dr_mag = dr[CB] ? (~dr + 1'b1) : dr;

  // equal deltas make the row axis major
  assign col_major_next = adc > adr;
  assign major_next     = col_major_next ? adc : adr;
  assign minor_next     = col_major_next ? adr : adc;
  assign d_init         = $signed({2'b00, minor_next, 1'b0}) - $signed({3'b000, major_next});

  assign two_major = $signed({2'b00, major, 1'b0});
  assign two_minor = $signed({2'b00, minor, 1'b0});
  assign move      = (d > 0) || (tie_moves && (d == 0));

  assign col_adv = col_neg ? (col - 1'b1) : (col + 1'b1);
  assign row_adv = row_neg ? (row - 1'b1) : (row + 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col     <= in_col;
      row     <= in_row;
      col_neg <= dc[CB];
      row_neg <= dr[CB];
      adc     <= dc_mag[CB-1:0];
      adr     <= dr_mag[CB-1:0];
    end
    if (cmd.setup) begin
      col_major <= col_major_next;
      major     <= major_next;
      minor     <= minor_next;
      cnt       <= major_next;
      d         <= d_init;
      // a tie moves the minor axis when signs differ on a column-major line,
      // or agree on a row-major line
      tie_moves <= col_major_next ? (col_neg != row_neg) : (col_neg == row_neg);
    end
    if (cmd.step) begin
      if (col_major) begin
        col <= col_adv;
        if (move) begin
          row <= row_adv;
        end
      end else begin
        row <= row_adv;
        if (move) begin
          col <= col_adv;
        end
      end
      d   <= move ? (d - two_major + two_minor) : (d + two_minor);
      cnt <= cnt - 1'b1;
    end
  end

  assign status.last = (cnt == '0);
  assign point_col   = col;
  assign point_row   = row;

endmodule

// ----- hdl/glpg_ctrl.sv -----
// controller state machine of the grid line point generator
module glpg_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  glpg_pkg::glpg_status_t status,
  output glpg_pkg::glpg_cmd_t    cmd
);
  import glpg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t state;

  always_comb begin
    cmd.load  = (state == ST_IDLE) && s_tvalid;
    cmd.setup = (state == ST_SETUP);
    cmd.step  = (state == ST_RUN) && m_tready && !status.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state    <= ST_SETUP;
            s_tready <= 1'b0;
          end
        end
        ST_SETUP: begin
          state    <= ST_RUN;
          m_tvalid <= 1'b1;
        end
        ST_RUN: begin
          if (m_tready && status.last) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          m_tvalid <= 1'b0;
          s_tready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- hdl/grid_line_point_generator_core.sv -----
// top level of the grid line point generator: controller plus datapath
// first cell: after the request item is accepted the controller seeds the datapath in the
//   setup state, then raises m_tvalid with the first cell in the run state
// requests: a new request is taken only once the last cell of the previous line is taken;
//   with no backpressure the datapath error term loop steps one cell per cycle
// reset: synchronous active-high rst returns the controller to idle, ready for a request;
//   datapath registers are not reset
module grid_line_point_generator_core #(
  parameter int COORD_BITS = glpg_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // request side
  input  logic s_tvalid,
  output logic s_tready,
  // start_col, start_row, end_col, end_row from bit 0 up, zero padded
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // cell side
  output logic m_tvalid,
  input  logic m_tready,
  // point_col, point_row from bit 0 up, zero padded
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  output logic m_tlast    // last_point
);
  import glpg_pkg::*;

  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  glpg_cmd_t              cmd;
  glpg_status_t           status;
  logic [COORD_BITS-1:0]  point_col;
  logic [COORD_BITS-1:0]  point_row;

  // sequencer: idle -> setup -> run one cell per accepted output item
  glpg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // coordinates and error term live here; only the packed fields reach the datapath
  glpg_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .req       (s_tdata[4*COORD_BITS-1:0]),
    .status    (status),
    .point_col (point_col),
    .point_row (point_row)
  );

  // current cell goes straight out of the datapath registers, held while stalled
  assign m_tdata = OUT_W'({point_row, point_col});
  // last cell when the remaining count has run out
  assign m_tlast = status.last;

endmodule

// ----- hdl/glpg_checker.sv -----
// port-level checker for the grid line point generator and its bind
module glpg_checker #(
  parameter int COORD_BITS = glpg_pkg::COORD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  input logic m_tlast
);

  // one request at a time: no request taken while cells are being shown
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request ready while cells pending");

  // an accepted request closes the request side
  a_req_closes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request side still ready after accept");

  // a stalled cell holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled cell changed");

  // cells keep coming until the last one is taken
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("line ended before last cell");

  // taking the last cell ends the line
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid && s_tready))
    else $error("line did not end after last cell");

endmodule

bind grid_line_point_generator_core glpg_checker #(
  .COORD_BITS (COORD_BITS)
) u_glpg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
